>>> rtl/vision_frame_steering_control_assert.svh
// Assertion macros for the steering block
`ifndef VISION_FRAME_STEERING_CONTROL_ASSERT_SVH
`define VISION_FRAME_STEERING_CONTROL_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define VFS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define VFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/vfsc_pkg.sv
// ----------------------------------------------------------------------------
// vfsc_pkg: shared types and constants
// Widths, codes and the arctangent table of the steering block.
// ----------------------------------------------------------------------------
`default_nettype none
package vfsc_pkg;
	localparam int CordicSteps = 16;
	localparam int StepW = $clog2(CordicSteps + 1);
	localparam int CordW = 44;
	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_TURN  = 2'd1;
	localparam logic [1:0] ACT_SPEED = 2'd2;
	localparam logic [2:0] REG_MIN_CONF = 3'd0;
	localparam logic [2:0] REG_HEAD_GAIN = 3'd1;
	localparam logic [2:0] REG_CT_DRIVE = 3'd2;
	localparam logic [2:0] REG_CT_ERR = 3'd3;
	localparam logic [2:0] REG_SOFT = 3'd4;
	localparam logic [2:0] REG_DAMP = 3'd5;
	localparam logic [2:0] REG_GYRO_NEG = 3'd6;
	localparam logic [2:0] REG_MAX_DRIVE = 3'd7;
	localparam logic [7:0] HEAD_BYTE = 8'hA5;
	localparam logic [7:0] TAIL_BYTE = 8'h5A;

	typedef struct packed {
		logic                start;
		logic signed [7:0]   err;
		logic [8:0]          den;
		logic [15:0]         gain;
	} cordic_req_t;

	function automatic logic signed [14:0] atan_q14(input logic [StepW-1:0] i);
		logic signed [14:0] v;
		case (i)
			0: v = 15'sd12868;
			1: v = 15'sd7596;
			2: v = 15'sd4014;
			3: v = 15'sd2037;
			4: v = 15'sd1023;
			5: v = 15'sd512;
			6: v = 15'sd256;
			7: v = 15'sd128;
			8: v = 15'sd64;
			9: v = 15'sd32;
			10: v = 15'sd16;
			11: v = 15'sd8;
			12: v = 15'sd4;
			13: v = 15'sd2;
			14: v = 15'sd1;
			default: v = 15'sd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

>>> rtl/vfsc_cordic.sv
// ----------------------------------------------------------------------------
// vfsc_cordic: iterative vectoring CORDIC
// One shift-add step per cycle; returns the angle in signed Q4.14 radians.
// ----------------------------------------------------------------------------
`default_nettype none
module vfsc_cordic (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire vfsc_pkg::cordic_req_t req,
	output logic                      done,
	output logic signed [17:0]        angle
);
	import vfsc_pkg::*;
	`include "vision_frame_steering_control_assert.svh"

	logic                     busy_q;
	logic [StepW-1:0]         step_q;
	logic signed [CordW-1:0]  x_q, y_q;
	logic signed [17:0]       z_q;
	logic                     done_q;
	logic signed [CordW-1:0]  xs, ys;
	logic signed [14:0]       at;
	logic signed [24:0]       y_seed;

	// arithmetic shift of a signed value is a floor shift
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = atan_q14(step_q);
	assign y_seed = 25'(req.err) * 25'($signed({1'b0, req.gain}));

	// x seed and y seed: y is err*gain (8x16 multiply, done once)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == StepW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= CordW'({req.den, 16'd0});
			y_q <= CordW'(y_seed);
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[CordW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + 18'(at);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - 18'(at);
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

	`VFS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held more than one cycle")
	`VFS_ASSERT(a_busy_step, busy_q, step_q < StepW'(CordicSteps), "step overran")
	`VFS_ASSERT(a_no_restart, busy_q, !req.start, "start while busy")
endmodule
`default_nettype wire

>>> rtl/vision_frame_steering_control.sv
// ----------------------------------------------------------------------------
// vision_frame_steering_control: vision frame parser and Stanley steering
// Parses 7-byte camera frames and computes a saturated turn drive.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | action, rx_byte, gyro_rate, requested_speed
// out     | output    | out_valid/stall | turn_drive, target_speed, frame_accepted,
//         |           |                 | vision_valid
// cfg     | input     | cfg_we          | cfg_index, cfg_data
//
// A byte or speed item, or a turn item while vision is not valid, goes from
// accept through the FIN state to OUT. A turn item with valid vision runs 16
// CORDIC steps in the shared shift-add unit, a done handoff, the MAC0, MAC1
// and MAC2 states on one shared multiplier and a round and saturate state (FIN).
// Reset returns the parser to the head hunt, clears held values, loads
// register defaults. The input is stalled while an item is in work or its
// result is still held.
`default_nettype none
module vision_frame_steering_control (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic [7:0]         rx_byte,
	input  wire logic signed [15:0] gyro_rate,
	input  wire logic signed [15:0] requested_speed,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      turn_drive,
	output logic [4:0]              target_speed,
	output logic                    frame_accepted,
	output logic                    vision_valid,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [17:0]        cfg_data
);
	import vfsc_pkg::*;
	`include "vision_frame_steering_control_assert.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CORD = 3'd1;
	localparam logic [2:0] ST_MAC0 = 3'd2;
	localparam logic [2:0] ST_MAC1 = 3'd3;
	localparam logic [2:0] ST_MAC2 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	// configuration registers
	logic [6:0]  min_conf_q;
	logic [15:0] head_gain_q, ct_err_q, damp_q;
	logic [17:0] ct_drive_q;
	logic [7:0]  soft_q;
	logic        gyro_neg_q;
	logic [14:0] max_drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= 7'd50;
			head_gain_q <= 16'd819;
			ct_drive_q <= 18'd66560;
			ct_err_q <= 16'd8520;
			soft_q <= 8'd10;
			damp_q <= 16'd307;
			gyro_neg_q <= 1'b0;
			max_drive_q <= 15'd520;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_CONF: min_conf_q <= cfg_data[6:0];
				REG_HEAD_GAIN: head_gain_q <= cfg_data[15:0];
				REG_CT_DRIVE: ct_drive_q <= cfg_data;
				REG_CT_ERR: ct_err_q <= cfg_data[15:0];
				REG_SOFT: soft_q <= cfg_data[7:0];
				REG_DAMP: damp_q <= cfg_data[15:0];
				REG_GYRO_NEG: gyro_neg_q <= cfg_data[0];
				REG_MAX_DRIVE: max_drive_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// frame storage and held vision values
	logic [7:0]        fb_q [1:5];
	logic [2:0]        pos_q;
	logic signed [7:0] herr_q, hslope_q;
	logic [6:0]        hconf_q;
	logic [4:0]        hspd_q;

	logic [2:0]               state_q;
	logic [1:0]               act_q;
	logic [7:0]               rx_q;
	logic signed [16:0]       gyro_q;
	logic signed [15:0]       req_q;
	logic signed [47:0]       acc_q;
	logic signed [15:0]       drive_q;
	logic [4:0]               tgt_q;
	logic                     facc_q;

	logic valid_now;
	assign valid_now = {1'b0, hconf_q} >= {1'b0, min_conf_q};

	// frame check on the byte held in rx_q
	logic [7:0]        sum8;
	logic signed [7:0] e_cl, s_cl;
	logic [6:0]        c_cl;
	logic [4:0]        v_cl;
	logic              frame_ok;
	assign sum8 = fb_q[1] + fb_q[2] + fb_q[3] + fb_q[4];
	assign frame_ok = (pos_q == 3'd6) && (rx_q == TAIL_BYTE) && (sum8 == fb_q[5]);
	always_comb begin
		e_cl = $signed(fb_q[1]);
		if (e_cl > 8'sd100) e_cl = 8'sd100;
		if (e_cl < -8'sd100) e_cl = -8'sd100;
		s_cl = $signed(fb_q[2]);
		if (s_cl > 8'sd100) s_cl = 8'sd100;
		if (s_cl < -8'sd100) s_cl = -8'sd100;
		c_cl = (fb_q[3] > 8'd100) ? 7'd100 : fb_q[3][6:0];
		v_cl = (fb_q[4] > 8'd30) ? 5'd30 : fb_q[4][4:0];
	end

	// shared CORDIC unit
	cordic_req_t        creq;
	logic               cdone;
	logic signed [17:0] cangle;
	logic [8:0]         den;
	// widen den: (spd+soft) can reach 9 bits
	assign den = 9'(soft_q) + 9'((hspd_q == 5'd0) ? 5'd1 : hspd_q);

	always_comb begin
		creq.start = (state_q == ST_IDLE) && in_valid && (action == ACT_TURN) && valid_now;
		creq.err   = herr_q;
		creq.den   = den;
		creq.gain  = ct_err_q;
	end

	vfsc_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (creq),
		.done  (cdone),
		.angle (cangle)
	);

	// shared multiplier: one product per MAC cycle
	logic signed [18:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [37:0] mul_p;
	always_comb begin
		case (state_q)
			ST_MAC0: begin
				mul_a = 19'(hslope_q);
				mul_b = $signed({3'b0, head_gain_q});
			end
			ST_MAC1: begin
				mul_a = cangle[17] ? {1'b1, cangle} : {1'b0, cangle};
				mul_b = $signed({1'b0, ct_drive_q});
			end
			ST_MAC2: begin
				mul_a = 19'(gyro_q);
				mul_b = $signed({3'b0, damp_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	logic signed [47:0] rnd;
	logic signed [25:0] r26;
	logic signed [25:0] lim;
	assign rnd = acc_q + 48'sd2097152;
	assign r26 = rnd[47:22];
	assign lim = $signed({11'd0, max_drive_q});

	logic in_acc, out_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= 3'd0;
			herr_q <= '0;
			hslope_q <= '0;
			hconf_q <= '0;
			hspd_q <= '0;
			act_q <= ACT_BYTE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) begin
					// hold the item; a turn with valid vision starts the CORDIC at once
					act_q <= action;
					state_q <= (action == ACT_TURN && valid_now) ? ST_CORD : ST_FIN;
				end
				ST_CORD: if (cdone) state_q <= ST_MAC0;
				ST_MAC0: state_q <= ST_MAC1;
				ST_MAC1: state_q <= ST_MAC2;
				ST_MAC2: state_q <= ST_FIN;
				ST_FIN: begin
					// advance the parser on a byte item
					if (act_q == ACT_BYTE) begin
						case (pos_q)
							3'd0: if (rx_q == HEAD_BYTE) pos_q <= 3'd1;
							3'd1, 3'd2, 3'd3, 3'd4, 3'd5: pos_q <= pos_q + 3'd1;
							default: pos_q <= 3'd0;
						endcase
						if (frame_ok) begin
							hconf_q <= c_cl;
							if (c_cl < min_conf_q) begin
								herr_q <= '0;
								hslope_q <= '0;
								hspd_q <= '0;
							end else begin
								herr_q <= e_cl;
								hslope_q <= s_cl;
								hspd_q <= v_cl;
							end
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_acc) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rx_q <= rx_byte;
			gyro_q <= gyro_neg_q ? -17'(gyro_rate) : 17'(gyro_rate);
			req_q <= requested_speed;
			drive_q <= '0;
			tgt_q <= '0;
			facc_q <= 1'b0;
			acc_q <= '0;
		end
		case (state_q)
			ST_MAC0: acc_q <= 48'(mul_p) <<< 14;
			ST_MAC1: acc_q <= acc_q + 48'(mul_p);
			ST_MAC2: acc_q <= acc_q - (48'(mul_p) <<< 14);
			ST_FIN: begin
				if (act_q == ACT_BYTE) begin
					facc_q <= frame_ok;
					if (pos_q >= 3'd1 && pos_q <= 3'd5) fb_q[pos_q] <= rx_q;
				end
				if (act_q == ACT_TURN && valid_now) begin
					if (r26 > lim) drive_q <= 16'(lim);
					else if (r26 < -lim) drive_q <= 16'(-lim);
					else drive_q <= 16'(r26);
				end
				if (act_q == ACT_SPEED && valid_now && hspd_q != 5'd0 && req_q > 16'sd0)
					tgt_q <= (req_q > 16'sd30) ? 5'd30 : req_q[4:0];
			end
			default: ;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);
	assign turn_drive = drive_q;
	assign target_speed = tgt_q;
	assign frame_accepted = facc_q;
	assign vision_valid = valid_now;

	`VFS_ASSERT(a_busy_stall, out_valid, in_stall, "input open while result pending")
	`VFS_ASSERT(a_accept_byte, out_valid && frame_accepted, act_q == ACT_BYTE,
		"frame flag on non-byte item")
	`VFS_ASSERT(a_pos_range, 1'b1, pos_q <= 3'd6, "parser position out of range")
	`VFS_ASSERT_NEXT(a_cord_done, state_q == ST_CORD && cdone, state_q == ST_MAC0,
		"sequencer missed CORDIC done")
endmodule
`default_nettype wire

>>> tb/tb_vision_frame_steering_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vision_frame_steering_control: self-checking bench for the steering block
// Feeds camera frames, turn and speed items under random idling, predicts each
// result from a behavioral copy of the parser and the CORDIC drive, and
// compares every result with the expectation.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_vision_frame_steering_control;
	import vfsc_pkg::*;

	localparam int MAX_CYCLES = 2000000;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         rx_byte;
		logic signed [15:0] gyro_rate;
		logic signed [15:0] requested_speed;
	} item_t;

	typedef struct packed {
		logic signed [15:0] turn_drive;
		logic [4:0]         target_speed;
		logic               frame_accepted;
		logic               vision_valid;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         action;
	logic [7:0]         rx_byte;
	logic signed [15:0] gyro_rate;
	logic signed [15:0] requested_speed;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] turn_drive;
	logic [4:0]         target_speed;
	logic               frame_accepted;
	logic               vision_valid;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [17:0]        cfg_data;

	vision_frame_steering_control uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .rx_byte(rx_byte), .gyro_rate(gyro_rate),
		.requested_speed(requested_speed),
		.out_valid(out_valid), .out_stall(out_stall),
		.turn_drive(turn_drive), .target_speed(target_speed),
		.frame_accepted(frame_accepted), .vision_valid(vision_valid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor copy of the configuration
	logic [6:0]  min_conf;
	logic [15:0] head_gain;
	logic [17:0] ct_drive_gain;
	logic [15:0] ct_err_gain;
	logic [7:0]  softening;
	logic [15:0] damp_gain;
	logic        gyro_neg;
	logic [14:0] drive_limit;

	// Predictor copy of the parser and held vision values
	logic [7:0]        frame_buf [0:5];
	int                frame_pos;
	logic signed [7:0] hold_err;
	logic signed [7:0] hold_slope;
	logic [6:0]        hold_conf;
	logic [4:0]        hold_speed;

	item_t   pending_items[$];
	result_t expected_results[$];
	int      mismatches;
	int      cycle_count;
	bit      stimulus_done;
	bit      quiet_phase;
	int      send_gap;
	int      recv_gap;
	// accepts seen at the rising edge and handled by the driver
	int      accepted_count = 0;
	int      taken_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	function automatic logic signed [7:0] clamp_hundred(input logic signed [7:0] v);
		if (v > 8'sd100) return 8'sd100;
		if (v < -8'sd100) return -8'sd100;
		return v;
	endfunction

	function automatic bit vision_ok();
		return hold_conf >= min_conf;
	endfunction

	// Advance the frame parser by one byte; return 1 on a completed valid frame
	function automatic bit parse_frame_byte(input logic [7:0] b);
		logic [7:0] sum;
		logic [6:0] conf;
		logic [4:0] spd;
		logic signed [7:0] e;
		logic signed [7:0] s;
		if (frame_pos == 0) begin
			if (b == HEAD_BYTE) begin
				frame_buf[0] = b;
				frame_pos = 1;
			end
			return 1'b0;
		end
		if (frame_pos < 6) begin
			frame_buf[frame_pos] = b;
			frame_pos++;
			return 1'b0;
		end
		frame_pos = 0;
		if (b != TAIL_BYTE) return 1'b0;
		sum = frame_buf[1] + frame_buf[2] + frame_buf[3] + frame_buf[4];
		if (sum != frame_buf[5]) return 1'b0;
		e = clamp_hundred(frame_buf[1]);
		s = clamp_hundred(frame_buf[2]);
		conf = (frame_buf[3] > 8'd100) ? 7'd100 : frame_buf[3][6:0];
		spd = (frame_buf[4] > 8'd30) ? 5'd30 : frame_buf[4][4:0];
		if (conf < min_conf) begin
			e = 0;
			s = 0;
			spd = 0;
		end
		hold_err = e;
		hold_slope = s;
		hold_conf = conf;
		hold_speed = spd;
		return 1'b1;
	endfunction

	function automatic logic signed [63:0] atan_step(input int i);
		case (i)
			0: return 12868;
			1: return 7596;
			2: return 4014;
			3: return 2037;
			4: return 1023;
			5: return 512;
			6: return 256;
			7: return 128;
			8: return 64;
			9: return 32;
			10: return 16;
			11: return 8;
			12: return 4;
			13: return 2;
			14: return 1;
			default: return 0;
		endcase
	endfunction

	// Stanley drive: heading + CORDIC crosstrack angle - damping, saturated
	function automatic logic signed [15:0] steering_drive(input logic signed [15:0] gyro);
		logic signed [63:0] x, y, z, nx, total, r, lim, g;
		if (!vision_ok()) return 16'sd0;
		g = gyro;
		if (gyro_neg) g = -g;
		x = (64'(hold_speed < 5'd1 ? 5'd1 : hold_speed) + 64'(softening)) * 65536;
		y = 64'(hold_err) * $signed({1'b0, ct_err_gain});
		z = 0;
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += atan_step(i);
			end else begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= atan_step(i);
			end
			x = nx;
		end
		total = 64'(hold_slope) * $signed({1'b0, head_gain}) * 16384
			+ z * $signed({1'b0, ct_drive_gain})
			- g * $signed({1'b0, damp_gain}) * 16384;
		r = floor_shift(total + (64'sd1 <<< 21), 22);
		lim = $signed({1'b0, drive_limit});
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[15:0];
	endfunction

	function automatic result_t predict_result(input item_t it);
		result_t res;
		res = '0;
		case (it.action)
			ACT_BYTE: res.frame_accepted = parse_frame_byte(it.rx_byte);
			ACT_TURN: res.turn_drive = steering_drive(it.gyro_rate);
			ACT_SPEED: begin
				if (vision_ok() && hold_speed != 0 && it.requested_speed > 0)
					res.target_speed = (it.requested_speed > 30) ? 5'd30
						: it.requested_speed[4:0];
			end
			default: ;
		endcase
		res.vision_valid = vision_ok();
		return res;
	endfunction

	// Driver: present the head of the queue, change inputs on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (accepted_count != taken_count) begin
			// item taken at the last rising edge; load the next or go idle
			taken_count = accepted_count;
			if (pending_items.size() > 0 && !quiet_phase && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 15);
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0 && send_gap == 0) begin
				{action, rx_byte, gyro_rate, requested_speed} <= pending_items[0];
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end else if (!in_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_items.size() > 0) begin
				{action, rx_byte, gyro_rate, requested_speed} <= pending_items[0];
				in_valid <= 1'b1;
			end
		end
		if (!arst_n || quiet_phase) begin
			out_stall <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 11) == 0) begin
			recv_gap = $urandom_range(1, 15);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predict on acceptance, then drop the item from the queue
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(predict_result(pending_items[0]));
			void'(pending_items.pop_front());
			accepted_count++;
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {turn_drive, target_speed, frame_accepted, vision_valid};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result drive=%0d speed=%0d acc=%0b valid=%0b",
						turn_drive, target_speed, frame_accepted, vision_valid);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp drive=%0d speed=%0d acc=%0b valid=%0b, got drive=%0d speed=%0d acc=%0b valid=%0b",
							want.turn_drive, want.target_speed, want.frame_accepted,
							want.vision_valid, got.turn_drive, got.target_speed,
							got.frame_accepted, got.vision_valid);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MIN_CONF: min_conf = val[6:0];
			REG_HEAD_GAIN: head_gain = val[15:0];
			REG_CT_DRIVE: ct_drive_gain = val[17:0];
			REG_CT_ERR: ct_err_gain = val[15:0];
			REG_SOFT: softening = val[7:0];
			REG_DAMP: damp_gain = val[15:0];
			REG_GYRO_NEG: gyro_neg = val[0];
			REG_MAX_DRIVE: drive_limit = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for the block to drain, then let turn work settle
	task automatic drain();
		while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_item(input logic [1:0] a, input logic [7:0] b,
		input logic signed [15:0] g, input logic signed [15:0] r);
		pending_items.push_back({a, b, g, r});
	endtask

	// Queue one frame; corrupt selects a bad checksum or tail
	task automatic push_frame(input logic [7:0] e, input logic [7:0] s, input logic [7:0] c,
		input logic [7:0] v, input int corrupt);
		logic [7:0] sum;
		sum = e + s + c + v;
		if (corrupt == 1) sum = sum ^ 8'h01;
		push_item(ACT_BYTE, HEAD_BYTE, $urandom, $urandom);
		push_item(ACT_BYTE, e, $urandom, $urandom);
		push_item(ACT_BYTE, s, $urandom, $urandom);
		push_item(ACT_BYTE, c, $urandom, $urandom);
		push_item(ACT_BYTE, v, $urandom, $urandom);
		push_item(ACT_BYTE, sum, $urandom, $urandom);
		push_item(ACT_BYTE, (corrupt == 2) ? 8'h5B : TAIL_BYTE, $urandom, $urandom);
	endtask

	task automatic push_random(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 30) begin
				push_frame($urandom, $urandom, ($urandom_range(0, 3) == 0) ? $urandom
					: $urandom_range(20, 110), ($urandom_range(0, 3) == 0) ? $urandom
					: $urandom_range(0, 40), ($urandom_range(0, 9) == 0)
					? $urandom_range(1, 2) : 0);
				i += 6;
			end else if (k < 60) begin
				push_item(ACT_TURN, $urandom, $urandom, $urandom);
			end else if (k < 80) begin
				push_item(ACT_SPEED, $urandom, $urandom, ($urandom_range(0, 1) == 0)
					? $urandom_range(0, 40) : $urandom);
			end else if (k < 95) begin
				push_item(ACT_BYTE, ($urandom_range(0, 2) == 0) ? HEAD_BYTE : $urandom,
					$urandom, $urandom);
			end else begin
				push_item(2'd3, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		logic [2:0] idx;
		// Hold every input at a known value through reset
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		action = ACT_BYTE;
		rx_byte = '0;
		gyro_rate = '0;
		requested_speed = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		cycle_count = 0;
		stimulus_done = 0;
		quiet_phase = 0;
		send_gap = 0;
		recv_gap = 0;
		min_conf = 7'd50;
		head_gain = 16'd819;
		ct_drive_gain = 18'd66560;
		ct_err_gain = 16'd8520;
		softening = 8'd10;
		damp_gain = 16'd307;
		gyro_neg = 1'b0;
		drive_limit = 15'd520;
		frame_pos = 0;
		hold_err = 0;
		hold_slope = 0;
		hold_conf = 0;
		hold_speed = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: turn and speed before any frame, then frames at the extremes
		push_item(ACT_TURN, 8'h00, 16'sh7FFF, 16'sd5);
		push_item(ACT_SPEED, 8'hFF, -16'sh8000, 16'sd10);
		push_frame(8'h7F, 8'h80, 8'hFF, 8'hFF, 0);
		push_item(ACT_TURN, 8'h00, -16'sh8000, 16'sh7FFF);
		push_item(ACT_SPEED, 8'h00, 16'sd0, 16'sh7FFF);
		push_item(ACT_SPEED, 8'h00, 16'sd0, 16'sd0);
		push_item(2'd3, 8'hFF, 16'sh7FFF, 16'sh7FFF);
		// head byte inside a frame is taken as data, bad tail and bad checksum drop
		push_frame(8'hA5, 8'h9C, 8'h32, 8'h00, 2);
		push_frame(8'h80, 8'h7F, 8'h64, 8'h1E, 1);
		drain();
		// Threshold low and high extremes, low confidence zeroes the held data
		write_reg(REG_MIN_CONF, 18'd101);
		push_frame(8'h10, 8'h10, 8'h64, 8'h10, 0);
		push_item(ACT_TURN, 8'h00, 16'sd100, 16'sd0);
		push_item(ACT_SPEED, 8'h00, 16'sd0, 16'sd20);
		drain();
		write_reg(REG_MIN_CONF, 18'd0);
		write_reg(REG_GYRO_NEG, 18'd1);
		write_reg(REG_MAX_DRIVE, 18'h7FFF);
		write_reg(REG_HEAD_GAIN, 18'hFFFF);
		write_reg(REG_CT_DRIVE, 18'h3FFFF);
		write_reg(REG_CT_ERR, 18'hFFFF);
		write_reg(REG_SOFT, 18'd0);
		write_reg(REG_DAMP, 18'hFFFF);
		push_frame(8'h9C, 8'h64, 8'h00, 8'h00, 0);
		push_item(ACT_TURN, 8'h00, 16'sh7FFF, 16'sd0);
		push_item(ACT_TURN, 8'h00, -16'sh8000, 16'sd0);
		push_random(200);
		// Pause the sender until every expected result is in
		drain();

		write_reg(REG_MIN_CONF, 18'd50);
		write_reg(REG_GYRO_NEG, 18'd0);
		write_reg(REG_MAX_DRIVE, 18'd0);
		write_reg(REG_SOFT, 18'd255);
		write_reg(REG_HEAD_GAIN, 18'd0);
		write_reg(REG_CT_DRIVE, 18'd0);
		write_reg(REG_CT_ERR, 18'd0);
		write_reg(REG_DAMP, 18'd0);
		push_random(150);
		drain();

		// Several random settings
		for (int p = 0; p < 4; p++) begin
			for (int r = 0; r < 8; r++) begin
				idx = 3'(r);
				write_reg(idx, (r == 0) ? 18'($urandom_range(0, 101)) : 18'($urandom));
			end
			push_random(200);
			drain();
		end

		write_reg(REG_MIN_CONF, 18'd50);
		write_reg(REG_HEAD_GAIN, 18'd819);
		write_reg(REG_CT_DRIVE, 18'd66560);
		write_reg(REG_CT_ERR, 18'd8520);
		write_reg(REG_SOFT, 18'd10);
		write_reg(REG_DAMP, 18'd307);
		write_reg(REG_GYRO_NEG, 18'd0);
		write_reg(REG_MAX_DRIVE, 18'd520);
		// Last part runs without idling
		quiet_phase = 1;
		push_random(100);
		drain();

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
